// ----- rtl/tld_pkg.sv -----
`default_nettype none

package tld_pkg;

	localparam int LINE_DEPTH = 32;
	localparam int ADDR_W = $clog2(LINE_DEPTH);
	localparam int CNT_W = $clog2(LINE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(LINE_DEPTH - 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CANONICAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_TERM = 2'd1;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_C = 8'h43;

	localparam logic DEST_TERM = 1'b0;
	localparam logic DEST_CLIENT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ECHO,
		ST_ECHO_CR,
		ST_FLUSH,
		ST_TERM,
		ST_ETX_CARET,
		ST_ETX_C,
		ST_ETX_CR,
		ST_ETX_SEND,
		ST_BS_ECHO
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/terminal_line_discipline_top.sv -----
`default_nettype none

// Canonical line editor between a terminal and a serial client. One input
// transfer is taken at a time; it produces between zero and LINE_DEPTH + 2
// output bytes at one byte per cycle unless the output stalls, so an item
// occupies the block until its results (up to 34 at LINE_DEPTH = 32) are issued.
// A line flush reads the line memory once per cycle through its registered
// read port, which paces the flush. The output register lets the next item be
// accepted while the final result still waits. After an end of transmission
// the block swallows all input until reset; configuration writes still land.
module terminal_line_discipline_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [tld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                         cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         req_type,
	input  wire logic [7:0]                   data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              dest,
	output logic [7:0]                        byte_out,
	output logic                              last
);
	import tld_pkg::*;

	state_t state_q, state_d;

	logic canon_q, keep_q;
	logic halted_q, halt_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic client_q;
	logic [7:0] c_q;

	logic [7:0] line_mem [LINE_DEPTH];
	logic [7:0] rd_q;
	logic [ADDR_W-1:0] rd_addr;
	logic we;

	logic can_load, ld, ld_dest, ld_last;
	logic [7:0] ld_byte;

	logic out_valid_q, dest_q, last_q;
	logic [7:0] byte_q;

	assign can_load = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign rd_addr = idx_d[ADDR_W-1:0];

	always_comb begin
		state_d = state_q;
		halt_d = halted_q;
		fill_d = fill_q;
		idx_d = idx_q;
		we = 1'b0;
		ld = 1'b0;
		ld_dest = DEST_TERM;
		ld_byte = c_q;
		ld_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !halted_q)
					state_d = ST_ECHO;
			end
			ST_ECHO: begin
				if (can_load) begin
					ld = 1'b1;
					if (client_q) begin
						ld_last = 1'b1;
						state_d = ST_IDLE;
						if (c_q == CH_EOT && !keep_q)
							halt_d = 1'b1;
					end else if (!canon_q) begin
						ld_dest = DEST_CLIENT;
						ld_last = 1'b1;
						state_d = ST_IDLE;
						if (c_q == CH_EOT)
							halt_d = 1'b1;
					end else begin
						unique case (c_q)
							CH_NL: state_d = ST_ECHO_CR;
							CH_CR, CH_EOT: begin
								idx_d = '0;
								state_d = (fill_q == '0) ? ST_TERM : ST_FLUSH;
							end
							CH_ETX: state_d = ST_ETX_CARET;
							CH_DEL, CH_BS: state_d = ST_BS_ECHO;
							default: begin
								ld_last = 1'b1;
								state_d = ST_IDLE;
								if (fill_q < FILL_MAX) begin
									we = 1'b1;
									fill_d = fill_q + CNT_W'(1);
								end
							end
						endcase
					end
				end
			end
			ST_ECHO_CR: begin
				if (can_load) begin
					ld = 1'b1;
					ld_byte = CH_CR;
					idx_d = '0;
					state_d = (fill_q == '0) ? ST_TERM : ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (can_load) begin
					ld = 1'b1;
					ld_dest = DEST_CLIENT;
					ld_byte = rd_q;
					idx_d = idx_q + CNT_W'(1);
					if (idx_q + CNT_W'(1) == fill_q)
						state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				if (can_load) begin
					ld = 1'b1;
					ld_dest = DEST_CLIENT;
					ld_byte = (c_q == CH_EOT) ? CH_EOT : CH_CR;
					ld_last = 1'b1;
					fill_d = '0;
					state_d = ST_IDLE;
					if (c_q == CH_EOT)
						halt_d = 1'b1;
				end
			end
			ST_ETX_CARET: begin
				if (can_load) begin
					ld = 1'b1;
					ld_byte = CH_CARET;
					state_d = ST_ETX_C;
				end
			end
			ST_ETX_C: begin
				if (can_load) begin
					ld = 1'b1;
					ld_byte = CH_C;
					state_d = ST_ETX_CR;
				end
			end
			ST_ETX_CR: begin
				if (can_load) begin
					ld = 1'b1;
					ld_byte = CH_CR;
					state_d = ST_ETX_SEND;
				end
			end
			ST_ETX_SEND: begin
				if (can_load) begin
					ld = 1'b1;
					ld_dest = DEST_CLIENT;
					ld_byte = CH_CR;
					ld_last = 1'b1;
					fill_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_BS_ECHO: begin
				if (can_load) begin
					ld = 1'b1;
					ld_byte = CH_BS;
					ld_last = 1'b1;
					if (fill_q != '0)
						fill_d = fill_q - CNT_W'(1);
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			halted_q <= 1'b0;
			fill_q <= '0;
			idx_q <= '0;
			canon_q <= 1'b0;
			keep_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			halted_q <= halt_d;
			fill_q <= fill_d;
			idx_q <= idx_d;
			if (cfg_we) begin
				if (cfg_index == REG_CANONICAL)
					canon_q <= cfg_data;
				else if (cfg_index == REG_KEEP_TERM)
					keep_q <= cfg_data;
			end
			if (ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// input capture and output payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			client_q <= req_type;
			c_q <= data;
		end
		if (ld) begin
			dest_q <= ld_dest;
			byte_q <= ld_byte;
			last_q <= ld_last;
		end
	end

	// line memory
	always_ff @(posedge clk) begin
		if (we)
			line_mem[fill_q[ADDR_W-1:0]] <= c_q;
		rd_q <= line_mem[rd_addr];
	end

	assign out_valid = out_valid_q;
	assign dest = dest_q;
	assign byte_out = byte_q;
	assign last = last_q;

endmodule

`default_nettype wire

// ----- rtl/tld_checker.sv -----
`default_nettype none

module tld_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       dest,
	input wire logic [7:0] byte_out,
	input wire logic       last
);

	// nothing pending out of reset
	a_reset_clean: assert property (@(posedge clk)
		!arst_n |-> !out_valid && in_ready)
		else $error("output pending or input blocked during reset");

	// a result that is not the last keeps the input side closed
	a_busy_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken before all results of an item were issued");

	// results of one item follow each other without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside the results of one item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(dest) && $stable(byte_out) && $stable(last))
		else $error("output payload changed while stalled");

endmodule

bind terminal_line_discipline_top tld_checker u_tld_checker (.*);

`default_nettype wire

// ----- sim/terminal_line_discipline_top_test.sv -----
`timescale 1ns / 1ps

module terminal_line_discipline_top_test;
	import tld_pkg::*;

	localparam logic REQ_TYPED = 1'b0;
	localparam logic REQ_CLIENT = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int SETTLE_CYCLES = 48;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic dest;
		logic [7:0] ch;
		logic last;
	} echo_byte_t;

	typedef enum int {
		EOT_LINE_FLUSH,
		EOT_RAW_TYPED,
		EOT_FROM_CLIENT
	} eot_case_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic cfg_data;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [7:0] data;
	logic out_valid;
	logic out_ready = 1'b0;
	logic dest;
	logic [7:0] byte_out;
	logic last;

	// line editor shadow state
	logic [7:0] line_buf [LINE_DEPTH];
	int unsigned line_len = 0;
	bit stopped = 1'b0;
	bit canon_cfg = 1'b0;
	bit keep_cfg = 1'b0;
	echo_byte_t pend;
	bit have_pend = 1'b0;
	echo_byte_t expected_q [$];
	echo_byte_t want;

	int errors = 0;
	int items_sent = 0;
	int items_in = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int send_gap_pct = 0;
	int rcv_stall_pct = 0;
	logic hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int stall_cycles = 0;

	terminal_line_discipline_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.data(data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest(dest),
		.byte_out(byte_out),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic emit(input logic d, input logic [7:0] ch);
		if (have_pend)
			expected_q.push_back(pend);
		pend.dest = d;
		pend.ch = ch;
		pend.last = 1'b0;
		have_pend = 1'b1;
	endtask

	task automatic predict_transfer(input logic rt, input logic [7:0] c_in);
		logic [7:0] c;
		int unsigned i;
		c = c_in;
		if (!stopped) begin
			if (rt == REQ_CLIENT) begin
				emit(DEST_TERM, c);
				if (c == CH_EOT && !keep_cfg)
					stopped = 1'b1;
			end else if (!canon_cfg) begin
				emit(DEST_CLIENT, c);
				if (c == CH_EOT)
					stopped = 1'b1;
			end else begin
				emit(DEST_TERM, c);
				if (c == CH_NL) begin
					c = CH_CR;
					emit(DEST_TERM, c);
				end
				if (c == CH_CR || c == CH_EOT) begin
					for (i = 0; i < line_len; i++)
						emit(DEST_CLIENT, line_buf[i]);
					emit(DEST_CLIENT, c);
					line_len = 0;
					if (c == CH_EOT)
						stopped = 1'b1;
				end else if (c == CH_ETX) begin
					emit(DEST_TERM, CH_CARET);
					emit(DEST_TERM, CH_C);
					emit(DEST_TERM, CH_CR);
					emit(DEST_CLIENT, CH_CR);
					line_len = 0;
				end else if (c == CH_DEL || c == CH_BS) begin
					emit(DEST_TERM, CH_BS);
					if (line_len > 0)
						line_len--;
				end else if (line_len < LINE_DEPTH - 1) begin
					line_buf[line_len] = c;
					line_len++;
				end
			end
		end
		if (have_pend) begin
			pend.last = 1'b1;
			expected_q.push_back(pend);
			have_pend = 1'b0;
		end
	endtask

	// register writes and input transfers feed the shadow state
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CANONICAL: canon_cfg = cfg_data;
					REG_KEEP_TERM: keep_cfg = cfg_data;
					default: ;
				endcase
				reg_writes++;
			end
			if (in_valid && in_ready) begin
				predict_transfer(req_type, data);
				items_in++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected output dest=%0b byte=%02h last=%0b",
					$time, dest, byte_out, last);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (dest !== want.dest) begin
					$display("%0t: dest expected %0b actual %0b", $time, want.dest, dest);
					errors++;
				end
				if (byte_out !== want.ch) begin
					$display("%0t: byte_out expected %02h actual %02h",
						$time, want.ch, byte_out);
					errors++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time, want.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, stall_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_CR || b == CH_NL || b == CH_EOT || b == CH_ETX ||
			b == CH_BS || b == CH_DEL);
		return b;
	endfunction

	task automatic send_byte(input logic rt, input logic [7:0] b);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		data <= b;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input bit canon, input bit keep);
		wait_idle();
		write_reg(REG_CANONICAL, canon);
		write_reg(REG_KEEP_TERM, keep);
	endtask

	task automatic send_client_noise(input bit keep);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (keep && $urandom_range(0, 7) == 0)
			b = CH_EOT;
		if (b == CH_EOT && !keep)
			b = CH_CR;
		send_byte(REQ_CLIENT, b);
	endtask

	task automatic send_random_line(input bit keep);
		int len;
		int i;
		int pick;
		if ($urandom_range(0, 99) < 15)
			len = $urandom_range(28, 40);
		else
			len = $urandom_range(0, 12);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_client_noise(keep);
			pick = $urandom_range(0, 99);
			if (pick < 6)
				send_byte(REQ_TYPED, CH_BS);
			else if (pick < 12)
				send_byte(REQ_TYPED, CH_DEL);
			else
				send_byte(REQ_TYPED, plain_byte());
		end
		pick = $urandom_range(0, 99);
		// the remaining share leaves the line open, possibly across a mode change
		if (pick < 40)
			send_byte(REQ_TYPED, CH_CR);
		else if (pick < 75)
			send_byte(REQ_TYPED, CH_NL);
		else if (pick < 90)
			send_byte(REQ_TYPED, CH_ETX);
	endtask

	task automatic send_raw_burst(input bit keep);
		logic [7:0] b;
		repeat ($urandom_range(5, 15)) begin
			if ($urandom_range(0, 3) == 0) begin
				send_client_noise(keep);
			end else begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_EOT)
					b = CH_ETX;
				send_byte(REQ_TYPED, b);
			end
		end
	endtask

	task automatic test_raw_passthrough();
		send_byte(REQ_TYPED, 8'h00);
		send_byte(REQ_TYPED, 8'hFF);
		send_byte(REQ_CLIENT, 8'hA5);
		send_byte(REQ_CLIENT, 8'h5A);
	endtask

	task automatic test_unused_registers();
		wait_idle();
		write_reg(REG_SPARE_2, 1'b1);
		write_reg(REG_SPARE_3, 1'b1);
		send_byte(REQ_TYPED, CH_CR);
	endtask

	task automatic test_line_editing();
		set_mode(1'b1, 1'b1);
		send_byte(REQ_CLIENT, CH_EOT);
		send_byte(REQ_TYPED, CH_BS);
		send_byte(REQ_TYPED, 8'h68);
		send_byte(REQ_TYPED, 8'h69);
		send_byte(REQ_TYPED, CH_DEL);
		send_byte(REQ_TYPED, 8'hFF);
		send_byte(REQ_TYPED, 8'h00);
		send_byte(REQ_TYPED, CH_NL);
		send_byte(REQ_TYPED, 8'h78);
		send_byte(REQ_TYPED, CH_ETX);
		send_byte(REQ_TYPED, CH_CR);
	endtask

	task automatic test_mode_switch_mid_line();
		send_byte(REQ_TYPED, 8'h71);
		set_mode(1'b0, 1'b1);
		send_byte(REQ_TYPED, 8'h72);
		set_mode(1'b1, 1'b1);
		send_byte(REQ_TYPED, CH_CR);
	endtask

	task automatic test_random_traffic(input int count);
		int start;
		int lines;
		bit canon;
		bit keep;
		start = items_sent;
		while (items_sent - start < count) begin
			canon = ($urandom_range(0, 3) != 0);
			keep = 1'($urandom_range(0, 1));
			set_mode(canon, keep);
			lines = $urandom_range(2, 4);
			repeat (lines) begin
				if (canon)
					send_random_line(keep);
				else
					send_raw_burst(keep);
			end
		end
	endtask

	task automatic test_output_backpressure();
		int i;
		set_mode(1'b1, 1'b1);
		hold_req <= 1'b1;
		@(posedge clk);
		for (i = 0; i < 20; i++)
			send_byte(REQ_TYPED, plain_byte());
		send_byte(REQ_TYPED, CH_CR);
		wait_idle();
	endtask

	task automatic test_end_of_transmission();
		eot_case_t which;
		int i;
		which = eot_case_t'($urandom_range(0, 2));
		case (which)
			EOT_LINE_FLUSH: begin
				set_mode(1'b1, 1'b1);
				repeat (4) send_byte(REQ_TYPED, plain_byte());
				send_byte(REQ_TYPED, CH_EOT);
			end
			EOT_RAW_TYPED: begin
				set_mode(1'b0, 1'b1);
				send_byte(REQ_TYPED, CH_EOT);
			end
			default: begin
				set_mode(1'b1, 1'b0);
				send_byte(REQ_CLIENT, CH_EOT);
			end
		endcase
		// halted: writes still land but every transfer is swallowed
		set_mode(1'b0, 1'b0);
		for (i = 0; i < 6; i++)
			send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CANONICAL;
		cfg_data <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_TYPED;
		data <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 16;
		rcv_stall_pct <= 45;
		test_raw_passthrough();
		test_unused_registers();
		test_line_editing();
		test_mode_switch_mid_line();
		test_random_traffic(45);

		send_gap_pct = 45;
		rcv_stall_pct <= 16;
		test_random_traffic(45);

		send_gap_pct = 0;
		rcv_stall_pct <= 0;
		test_output_backpressure();
		test_random_traffic(35);
		test_end_of_transmission();

		if (expected_q.size() != 0) begin
			$display("%0t: %0d expected outputs never arrived", $time, expected_q.size());
			errors++;
		end
		$display("%0d input transfers and %0d output transfers checked, %0d register writes",
			items_in, results_seen, reg_writes);
		$display("raw and canonical modes, line edits, full lines, hold-off, end of session");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
